>>> rtl/vlic_pkg.sv
package vlic_pkg;

    localparam logic [7:0] FAST_HALF_TICKS = 8'd3;
    localparam logic [7:0] SLOW_HALF_TICKS = 8'd10;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALARM_DISTANCE  = 3'd0,
        REG_STEER_LIMIT     = 3'd1,
        REG_LIGHT_ON_LEVEL  = 3'd2,
        REG_LIGHT_OFF_LEVEL = 3'd3,
        REG_LIGHT_STABLE    = 3'd4,
        REG_BRAKE_MIN_SPEED = 3'd5,
        REG_BRAKE_DROP      = 3'd6,
        REG_SOS_HOLD        = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_TURN   = 2'd1,
        MODE_SOS    = 2'd2
    } light_mode_t;

    typedef struct packed {
        logic [15:0] alarm_distance_mm;
        logic [6:0]  steer_limit;
        logic [7:0]  light_on_level;
        logic [7:0]  light_off_level;
        logic [7:0]  light_stable_ticks;
        logic [15:0] brake_min_speed;
        logic [15:0] brake_speed_drop;
        logic [7:0]  sos_hold_ticks;
    } lamp_cfg_t;

    typedef struct packed {
        logic        left_lamp;
        logic        right_lamp;
        logic        lamp_update;
        light_mode_t light_mode;
    } lamp_result_t;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

endpackage

>>> rtl/vlic_if.sv
interface vlic_tick_if;
    logic        valid;
    logic        ready;
    logic        aeb_active;
    logic        range_valid;
    logic [15:0] distance_mm;
    logic signed [7:0] steer_angle;
    logic [15:0] vehicle_speed;
    logic [7:0]  ambient_light;

    modport source (
        output valid, aeb_active, range_valid, distance_mm, steer_angle,
               vehicle_speed, ambient_light,
        input  ready
    );
    modport sink (
        input  valid, aeb_active, range_valid, distance_mm, steer_angle,
               vehicle_speed, ambient_light,
        output ready
    );
endinterface

interface vlic_lamp_if;
    logic       valid;
    logic       ready;
    logic       left_lamp;
    logic       right_lamp;
    logic       lamp_update;
    logic [1:0] light_mode;

    modport source (
        output valid, left_lamp, right_lamp, lamp_update, light_mode,
        input  ready
    );
    modport sink (
        input  valid, left_lamp, right_lamp, lamp_update, light_mode,
        output ready
    );
endinterface

interface vlic_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/vehicle_lamp_indicator_controller.sv
// Vehicle lamp indicator controller.
// Channels: tick (sink) takes one sensor snapshot per request; lamp (source)
// returns one result per request with both lamp bits, an update flag and the
// blink mode; cfg (sink) writes one of eight settings by index, always ready.
// The result is registered, valid in the cycle after its tick is taken.
// Throughput: one tick per cycle while the result register can load; all
// evaluation is one pass of compare/counter logic, state to result register.
// Stall: the result register holds until lamp.ready; tick.ready stays high
// while the register is empty or being drained in the same cycle, so a
// stalled receiver backs up the sender by exactly one entry.
// Reset: settings return to defaults, all counters and lamp history clear,
// headlights off, and the first result always flags an update.
// The user must write settings only while no tick is in flight; not enforced.
module vehicle_lamp_indicator_controller
    import vlic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vlic_tick_if.sink   tick,
    vlic_lamp_if.source lamp,
    vlic_cfg_if.sink    cfg
);

    lamp_cfg_t    cfg_val;
    lamp_result_t result;
    logic         can_load;
    logic         accept;

    assign tick.ready = can_load;
    assign accept     = tick.valid && can_load;

    vlic_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    vlic_tick_eval u_tick_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .aeb_active    (tick.aeb_active),
        .range_valid   (tick.range_valid),
        .distance_mm   (tick.distance_mm),
        .steer_angle   (tick.steer_angle),
        .vehicle_speed (tick.vehicle_speed),
        .ambient_light (tick.ambient_light),
        .cfg           (cfg_val),
        .result        (result)
    );

    vlic_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .lamp     (lamp)
    );

endmodule

>>> rtl/vlic_cfg_regs.sv
module vlic_cfg_regs
    import vlic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vlic_cfg_if.sink   cfg,
    output lamp_cfg_t  cfg_out
);

    lamp_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_distance_mm  <= 16'd50;
            cfg_reg.steer_limit        <= 7'd15;
            cfg_reg.light_on_level     <= 8'd80;
            cfg_reg.light_off_level    <= 8'd150;
            cfg_reg.light_stable_ticks <= 8'd60;
            cfg_reg.brake_min_speed    <= 16'd500;
            cfg_reg.brake_speed_drop   <= 16'd200;
            cfg_reg.sos_hold_ticks     <= 8'd100;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                REG_ALARM_DISTANCE:  cfg_reg.alarm_distance_mm  <= cfg.data;
                REG_STEER_LIMIT:     cfg_reg.steer_limit        <= cfg.data[6:0];
                REG_LIGHT_ON_LEVEL:  cfg_reg.light_on_level     <= cfg.data[7:0];
                REG_LIGHT_OFF_LEVEL: cfg_reg.light_off_level    <= cfg.data[7:0];
                REG_LIGHT_STABLE:    cfg_reg.light_stable_ticks <= cfg.data[7:0];
                REG_BRAKE_MIN_SPEED: cfg_reg.brake_min_speed    <= cfg.data;
                REG_BRAKE_DROP:      cfg_reg.brake_speed_drop   <= cfg.data;
                REG_SOS_HOLD:        cfg_reg.sos_hold_ticks     <= cfg.data[7:0];
            endcase
        end
    end

endmodule

>>> rtl/vlic_tick_eval.sv
module vlic_tick_eval
    import vlic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              aeb_active,
    input  logic              range_valid,
    input  logic [15:0]       distance_mm,
    input  logic signed [7:0] steer_angle,
    input  logic [15:0]       vehicle_speed,
    input  logic [7:0]        ambient_light,
    input  lamp_cfg_t         cfg,
    output lamp_result_t      result
);

    logic [7:0]  sos_count_reg, sos_count_next;
    logic [7:0]  blink_count_reg, blink_count_next;
    logic        blink_phase_reg, blink_phase_next;
    logic [15:0] last_speed_reg;
    logic        headlights_reg, headlights_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic        last_left_reg, last_left_next;
    logic        last_right_reg, last_right_next;
    logic        written_reg, written_next;

    logic              alarm;
    logic signed [8:0] steer_ext;
    logic signed [8:0] thr_ext;
    logic              go_left;
    logic              go_right;
    logic              turning;
    logic [16:0]       speed_sum;
    logic              braking;
    logic              qualify;
    logic [7:0]        run_inc;
    logic [7:0]        blink_inc;
    logic [7:0]        half;
    logic              steady;
    logic              left;
    logic              right;
    logic              sos_on;

    always_comb
    begin
        alarm     = aeb_active || (range_valid && (distance_mm < cfg.alarm_distance_mm));
        steer_ext = {steer_angle[7], steer_angle};
        thr_ext   = $signed({2'b00, cfg.steer_limit});
        go_left    = steer_ext < -thr_ext;
        go_right   = steer_ext > thr_ext;
        turning    = go_left || go_right;
        speed_sum  = {1'b0, vehicle_speed} + {1'b0, cfg.brake_speed_drop};
        braking    = (last_speed_reg > cfg.brake_min_speed) &&
                     (speed_sum < {1'b0, last_speed_reg});

        // headlight hysteresis
        qualify = headlights_reg ? (ambient_light > cfg.light_off_level)
                                 : (ambient_light < cfg.light_on_level);
        run_inc         = sat_inc8(run_count_reg);
        headlights_next = headlights_reg;
        run_count_next  = 8'd0;
        if (qualify)
        begin
            if (run_inc >= cfg.light_stable_ticks)
                headlights_next = ~headlights_reg;
            else
                run_count_next = run_inc;
        end

        if (alarm)
            sos_count_next = cfg.sos_hold_ticks;
        else if (sos_count_reg != 8'd0)
            sos_count_next = sos_count_reg - 8'd1;
        else
            sos_count_next = 8'd0;
        sos_on = sos_count_next != 8'd0;

        half = sos_on ? FAST_HALF_TICKS : (turning ? SLOW_HALF_TICKS : 8'd0);
        blink_inc        = sat_inc8(blink_count_reg);
        blink_count_next = 8'd0;
        blink_phase_next = 1'b1;
        if (half != 8'd0)
        begin
            blink_phase_next = blink_phase_reg;
            if (blink_inc >= half)
                blink_phase_next = ~blink_phase_reg;
            else
                blink_count_next = blink_inc;
        end

        steady = headlights_next || braking;
        if (sos_on)
        begin
            left  = blink_phase_next;
            right = blink_phase_next;
            result.light_mode = MODE_SOS;
        end
        else if (turning)
        begin
            left  = go_left ? blink_phase_next : steady;
            right = go_right ? blink_phase_next : steady;
            result.light_mode = MODE_TURN;
        end
        else
        begin
            left  = steady;
            right = steady;
            result.light_mode = MODE_STEADY;
        end

        result.left_lamp   = left;
        result.right_lamp  = right;
        result.lamp_update = !written_reg || (left != last_left_reg) ||
                             (right != last_right_reg);
        last_left_next  = result.lamp_update ? left : last_left_reg;
        last_right_next = result.lamp_update ? right : last_right_reg;
        written_next    = written_reg || result.lamp_update;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sos_count_reg   <= 8'd0;
            blink_count_reg <= 8'd0;
            blink_phase_reg <= 1'b0;
            last_speed_reg  <= 16'd0;
            headlights_reg  <= 1'b0;
            run_count_reg   <= 8'd0;
            last_left_reg   <= 1'b0;
            last_right_reg  <= 1'b0;
            written_reg     <= 1'b0;
        end
        else if (accept)
        begin
            sos_count_reg   <= sos_count_next;
            blink_count_reg <= blink_count_next;
            blink_phase_reg <= blink_phase_next;
            last_speed_reg  <= vehicle_speed;
            headlights_reg  <= headlights_next;
            run_count_reg   <= run_count_next;
            last_left_reg   <= last_left_next;
            last_right_reg  <= last_right_next;
            written_reg     <= written_next;
        end
    end

endmodule

>>> rtl/vlic_out_stage.sv
module vlic_out_stage
    import vlic_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  lamp_result_t result,
    output logic         can_load,
    vlic_lamp_if.source  lamp
);

    logic         valid_reg;
    lamp_result_t data_reg;

    assign can_load         = !valid_reg || lamp.ready;
    assign lamp.valid       = valid_reg;
    assign lamp.left_lamp   = data_reg.left_lamp;
    assign lamp.right_lamp  = data_reg.right_lamp;
    assign lamp.lamp_update = data_reg.lamp_update;
    assign lamp.light_mode  = data_reg.light_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

endmodule

>>> bench/vehicle_lamp_indicator_controller_test.sv
module vehicle_lamp_indicator_controller_test;
    import vlic_pkg::*;

    localparam int PHASES          = 6;
    localparam int TICKS_PER_PHASE = 300;
    localparam int HOLD_CYCLES     = 80;
    localparam int STUCK_LIMIT     = 2000;
    localparam int DIRECTED_ROWS   = 23;

    typedef struct packed {
        logic        aeb;
        logic        rv;
        logic [15:0] range_mm;
        logic [7:0]  steer;
        logic [15:0] speed;
        logic [7:0]  light;
    } tick_t;

    typedef struct packed {
        logic        aeb;
        logic        rv;
        logic [15:0] range_mm;
        logic [7:0]  steer;
        logic [15:0] speed;
        logic [7:0]  light;
        logic        typed;
        logic        w_left;
        logic        w_right;
        logic        w_upd;
        light_mode_t w_mode;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    vlic_tick_if tick();
    vlic_lamp_if lamp();
    vlic_cfg_if  cfg();

    vehicle_lamp_indicator_controller uut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .lamp  (lamp),
        .cfg   (cfg)
    );

    // directed rows on reset settings; typed rows carry their own expectation
    row_t plan [DIRECTED_ROWS] = '{
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd0,     8'd200, 1'b1, 1'b0, 1'b0, 1'b1, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd0,     8'd200, 1'b1, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd16,   16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     -8'sd16,  16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd15,   16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     -8'sd15,  16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'h7F,    16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'h80,    16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd100,  16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     -8'sd100, 16'd0,     8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd65535, 8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd0,     8'd200, 1'b1, 1'b1, 1'b1, 1'b1, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd701,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd500,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd300,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd300,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd300,   8'd255, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b0, 16'd0,     8'sd0,    16'd300,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b1, 16'd50,    8'sd0,    16'd300,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b1, 16'd49,    8'sd0,    16'd300,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b0, 1'b1, 16'd65535, 8'sd20,   16'd300,   8'd200, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b1, 1'b1, 16'd0,     8'h80,    16'd65535, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY},
        '{1'b1, 1'b1, 16'd65535, 8'h7F,    16'd65535, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, MODE_STEADY}
    };

    lamp_cfg_t   lcfg;
    logic [7:0]  sos_left    = 8'd0;
    logic [7:0]  blink_cnt   = 8'd0;
    logic        blink_ph    = 1'b0;
    logic [15:0] speed_was   = 16'd0;
    logic        head_on     = 1'b0;
    logic [7:0]  light_run   = 8'd0;
    logic        shown_left  = 1'b0;
    logic        shown_right = 1'b0;
    logic        shown_valid = 1'b0;

    lamp_result_t lamp_expect [$];
    lamp_result_t want;
    lamp_result_t typed_want;
    tick_t        row_tick;

    int gen_steer;
    int gen_speed;
    int gen_light;

    int send_idle;
    int recv_idle;
    bit hold_pending;
    int hold_left;

    int fails;
    int ticks_sent;
    int results_seen;
    int turn_seen;
    int sos_seen;
    int update_seen;
    int writes_done;
    int stuck;

    int i;
    int n;
    int ph;
    cfg_index_t  idx;
    logic [15:0] setting [8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lamp_result_t predict_lamps(input tick_t t);
        int steer;
        int thr;
        int half;
        bit alarm;
        bit go_left;
        bit go_right;
        bit braking;
        bit qualify;
        bit steady;
        lamp_result_t r;

        steer    = $signed(t.steer);
        thr      = int'(lcfg.steer_limit);
        alarm    = t.aeb || (t.rv && t.range_mm < lcfg.alarm_distance_mm);
        go_left  = steer < -thr;
        go_right = steer > thr;
        braking  = (speed_was > lcfg.brake_min_speed) &&
                   (({1'b0, t.speed} + {1'b0, lcfg.brake_speed_drop}) < {1'b0, speed_was});

        qualify = head_on ? (t.light > lcfg.light_off_level) : (t.light < lcfg.light_on_level);
        if (qualify)
        begin
            if (light_run != 8'hFF)
                light_run = light_run + 8'd1;
            if (light_run >= lcfg.light_stable_ticks)
            begin
                head_on   = !head_on;
                light_run = 8'd0;
            end
        end
        else
            light_run = 8'd0;

        speed_was = t.speed;

        if (alarm)
            sos_left = lcfg.sos_hold_ticks;
        else if (sos_left != 8'd0)
            sos_left = sos_left - 8'd1;

        half = (sos_left != 8'd0) ? int'(FAST_HALF_TICKS) :
               (go_left || go_right) ? int'(SLOW_HALF_TICKS) : 0;
        if (blink_cnt != 8'hFF)
            blink_cnt = blink_cnt + 8'd1;
        if (half > 0)
        begin
            if (blink_cnt >= half)
            begin
                blink_ph  = !blink_ph;
                blink_cnt = 8'd0;
            end
        end
        else
        begin
            blink_cnt = 8'd0;
            blink_ph  = 1'b1;
        end

        steady = head_on || braking;
        if (sos_left != 8'd0)
        begin
            r.left_lamp  = blink_ph;
            r.right_lamp = blink_ph;
            r.light_mode = MODE_SOS;
        end
        else if (go_left || go_right)
        begin
            r.left_lamp  = go_left ? blink_ph : steady;
            r.right_lamp = go_right ? blink_ph : steady;
            r.light_mode = MODE_TURN;
        end
        else
        begin
            r.left_lamp  = steady;
            r.right_lamp = steady;
            r.light_mode = MODE_STEADY;
        end

        r.lamp_update = !shown_valid || r.left_lamp != shown_left ||
                        r.right_lamp != shown_right;
        if (r.lamp_update)
        begin
            shown_left  = r.left_lamp;
            shown_right = r.right_lamp;
            shown_valid = 1'b1;
        end
        return r;
    endfunction

    // sticky steering, speed random walk with hard drops, light in plateaus
    function automatic tick_t random_tick();
        tick_t t;
        int mag;
        int pick;

        pick = $urandom_range(99);
        if (pick < 15)
        begin
            case ($urandom_range(2))
                0:
                begin
                    mag = int'(lcfg.steer_limit) + int'($urandom_range(4)) - 2;
                    if (mag < 0)
                        mag = 0;
                    else if (mag > 127)
                        mag = 127;
                    gen_steer = $urandom_range(1) ? mag : -mag;
                end
                1: gen_steer = int'($urandom_range(200)) - 100;
                default: gen_steer = int'($urandom_range(255)) - 128;
            endcase
        end
        t.steer = gen_steer[7:0];

        pick = $urandom_range(99);
        if (pick < 80)
            gen_speed = gen_speed + int'($urandom_range(300)) - 150;
        else if (pick < 92)
            gen_speed = gen_speed - int'($urandom_range(3000));
        else if (pick < 97)
            gen_speed = int'($urandom_range(65535));
        else
            gen_speed = $urandom_range(1) ? 65535 : 0;
        if (gen_speed < 0)
            gen_speed = 0;
        else if (gen_speed > 65535)
            gen_speed = 65535;
        t.speed = gen_speed[15:0];

        pick = $urandom_range(99);
        if (pick < 8)
            gen_light = int'($urandom_range(255));
        else if (pick < 10)
            gen_light = $urandom_range(1) ? 255 : 0;
        mag = gen_light + int'($urandom_range(16)) - 8;
        if (mag < 0)
            mag = 0;
        else if (mag > 255)
            mag = 255;
        t.light = mag[7:0];

        t.aeb = ($urandom_range(99) < 2);
        t.rv  = ($urandom_range(99) < 70);
        if ($urandom_range(99) < 6)
        begin
            mag = int'(lcfg.alarm_distance_mm) + int'($urandom_range(20)) - 10;
            if (mag < 0)
                mag = 0;
            else if (mag > 65535)
                mag = 65535;
            t.range_mm = mag[15:0];
        end
        else
            t.range_mm = 16'($urandom_range(65535));
        return t;
    endfunction

    task automatic offer_tick(input tick_t t, input logic typed, input lamp_result_t typed_res);
        lamp_result_t pred;

        while ($urandom_range(99) < send_idle)
        begin
            @(negedge clk);
            tick.valid <= 1'b0;
        end
        @(negedge clk);
        tick.valid         <= 1'b1;
        tick.aeb_active    <= t.aeb;
        tick.range_valid   <= t.rv;
        tick.distance_mm   <= t.range_mm;
        tick.steer_angle   <= t.steer;
        tick.vehicle_speed <= t.speed;
        tick.ambient_light <= t.light;
        do @(posedge clk); while (!tick.ready);
        pred = predict_lamps(t);
        lamp_expect.push_back(typed ? typed_res : pred);
        ticks_sent++;
    endtask

    task automatic write_setting(input cfg_index_t reg_idx, input logic [15:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= reg_idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        case (reg_idx)
            REG_ALARM_DISTANCE:  lcfg.alarm_distance_mm  = value;
            REG_STEER_LIMIT:     lcfg.steer_limit        = value[6:0];
            REG_LIGHT_ON_LEVEL:  lcfg.light_on_level     = value[7:0];
            REG_LIGHT_OFF_LEVEL: lcfg.light_off_level    = value[7:0];
            REG_LIGHT_STABLE:    lcfg.light_stable_ticks = value[7:0];
            REG_BRAKE_MIN_SPEED: lcfg.brake_min_speed    = value;
            REG_BRAKE_DROP:      lcfg.brake_speed_drop   = value;
            REG_SOS_HOLD:        lcfg.sos_hold_ticks     = value[7:0];
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_pending)
        begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            lamp.ready <= 1'b0;
        end
        else
            lamp.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && lamp.valid && lamp.ready)
        begin
            if (lamp_expect.size() == 0)
            begin
                $error("lamp result with no request outstanding");
                fails++;
            end
            else
            begin
                want = lamp_expect.pop_front();
                results_seen++;
                if (want.light_mode == MODE_TURN)
                    turn_seen++;
                if (want.light_mode == MODE_SOS)
                    sos_seen++;
                if (want.lamp_update)
                    update_seen++;
                if (lamp.left_lamp !== want.left_lamp)
                begin
                    $error("left_lamp: expected %0d, got %0d", want.left_lamp, lamp.left_lamp);
                    fails++;
                end
                if (lamp.right_lamp !== want.right_lamp)
                begin
                    $error("right_lamp: expected %0d, got %0d", want.right_lamp,
                           lamp.right_lamp);
                    fails++;
                end
                if (lamp.lamp_update !== want.lamp_update)
                begin
                    $error("lamp_update: expected %0d, got %0d", want.lamp_update,
                           lamp.lamp_update);
                    fails++;
                end
                if (lamp.light_mode !== want.light_mode)
                begin
                    $error("light_mode: expected %0d, got %0d", want.light_mode,
                           lamp.light_mode);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((tick.valid && tick.ready) || (lamp.valid && lamp.ready) ||
                (cfg.valid && cfg.ready))
                stuck = 0;
            else
            begin
                stuck++;
                if (stuck == STUCK_LIMIT)
                begin
                    $display("no progress for %0d cycles", STUCK_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        tick.valid         = 1'b0;
        tick.aeb_active    = 1'b0;
        tick.range_valid   = 1'b0;
        tick.distance_mm   = 16'd0;
        tick.steer_angle   = 8'sd0;
        tick.vehicle_speed = 16'd0;
        tick.ambient_light = 8'd0;
        lamp.ready         = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_ALARM_DISTANCE;
        cfg.data           = 16'd0;
        lcfg = '{16'd50, 7'd15, 8'd80, 8'd150, 8'd60, 16'd500, 16'd200, 8'd100};
        gen_steer = 0;
        gen_speed = 1000;
        gen_light = 200;
        hold_pending = 1'b0;
        hold_left = 0;
        fails = 0;
        stuck = 0;
        send_idle = 0;
        recv_idle = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle = 6;
                    recv_idle = 71;
                end
                1:
                begin
                    send_idle = 71;
                    recv_idle = 6;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase

            if (ph > 0)
            begin
                while (lamp_expect.size() != 0) @(posedge clk);
                repeat (3) @(posedge clk);
                case (ph)
                    1: setting = '{default: 16'd0};
                    2: setting = '{default: 16'hFFFF};
                    3:
                    begin
                        setting[REG_ALARM_DISTANCE]  = 16'd300;
                        setting[REG_STEER_LIMIT]     = 16'd20;
                        setting[REG_LIGHT_ON_LEVEL]  = 16'd60;
                        setting[REG_LIGHT_OFF_LEVEL] = 16'd180;
                        setting[REG_LIGHT_STABLE]    = 16'd3;
                        setting[REG_BRAKE_MIN_SPEED] = 16'd1000;
                        setting[REG_BRAKE_DROP]      = 16'd100;
                        setting[REG_SOS_HOLD]        = 16'd6;
                    end
                    4:
                    begin
                        setting[REG_ALARM_DISTANCE]  = 16'($urandom_range(2000));
                        setting[REG_STEER_LIMIT]     = 16'($urandom_range(100));
                        setting[REG_LIGHT_ON_LEVEL]  = 16'($urandom_range(255));
                        setting[REG_LIGHT_OFF_LEVEL] = 16'($urandom_range(255));
                        setting[REG_LIGHT_STABLE]    = 16'($urandom_range(8, 1));
                        setting[REG_BRAKE_MIN_SPEED] = 16'($urandom_range(3000));
                        setting[REG_BRAKE_DROP]      = 16'($urandom_range(800));
                        setting[REG_SOS_HOLD]        = 16'($urandom_range(12, 1));
                    end
                    default:
                    begin
                        for (i = 0; i < 8; i++)
                            setting[i] = 16'($urandom_range(65535));
                        // large drop so that speed plus drop overflows 16 bits
                        setting[REG_BRAKE_DROP] = 16'($urandom_range(65535, 60000));
                    end
                endcase
                idx = idx.first();
                repeat (8)
                begin
                    write_setting(idx, setting[idx]);
                    idx = idx.next();
                end
            end

            if (ph == 0)
            begin
                for (i = 0; i < DIRECTED_ROWS; i++)
                begin
                    row_tick   = '{plan[i].aeb, plan[i].rv, plan[i].range_mm, plan[i].steer,
                                   plan[i].speed, plan[i].light};
                    typed_want = '{plan[i].w_left, plan[i].w_right, plan[i].w_upd,
                                   plan[i].w_mode};
                    offer_tick(row_tick, plan[i].typed, typed_want);
                end
            end

            for (n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (n == TICKS_PER_PHASE / 2)
                    hold_pending = 1'b1;
                if (n == 3 * TICKS_PER_PHASE / 4)
                begin
                    @(negedge clk);
                    tick.valid <= 1'b0;
                    while (lamp_expect.size() != 0) @(posedge clk);
                end
                offer_tick(random_tick(), 1'b0, '0);
            end
            @(negedge clk);
            tick.valid <= 1'b0;
        end

        while (lamp_expect.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d ticks sent under %0d register settings, %0d register writes",
                 ticks_sent, PHASES, writes_done);
        $display("%0d lamp results compared: %0d turn blink, %0d SOS blink, %0d updates",
                 results_seen, turn_seen, sos_seen, update_seen);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> vehicle_lamp_indicator_controller.f
rtl/vlic_pkg.sv
rtl/vlic_if.sv
rtl/vlic_cfg_regs.sv
rtl/vlic_tick_eval.sv
rtl/vlic_out_stage.sv
rtl/vehicle_lamp_indicator_controller.sv
bench/vehicle_lamp_indicator_controller_test.sv
